// ===== rtl/ffa_pkg.sv =====
// Package for the first-fit file space allocator.
// Holds widths, command and status codes and the default register values.
package ffa_pkg;

  localparam int OFS_W   = 48;
  localparam int VER_W   = 32;
  localparam int STEP_W  = 31;
  localparam int CNT_OUT_W = 7;
  localparam int ENTRY_W = 2 * OFS_W + VER_W;

  localparam int MAX_EXTENTS_DEF = 64;

  localparam logic [OFS_W-1:0]  OFS_MAX         = {OFS_W{1'b1}};
  localparam logic [VER_W-1:0]  READLOCK_RST    = {VER_W{1'b1}};
  localparam logic [STEP_W-1:0] GROWTH_STEP_RST = STEP_W'(1024 * 1024);

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_PROBE  = 2'd1;
  localparam logic [1:0] CMD_APPEND = 2'd2;
  localparam logic [1:0] CMD_CLEAR  = 2'd3;

  localparam logic [1:0] ST_REUSED   = 2'd0;
  localparam logic [1:0] ST_EXPANDED = 2'd1;
  localparam logic [1:0] ST_REFUSED  = 2'd2;
  localparam logic [1:0] ST_LISTDONE = 2'd3;

  localparam logic [1:0] REG_SHARED   = 2'd0;
  localparam logic [1:0] REG_READLOCK = 2'd1;
  localparam logic [1:0] REG_GROWTH   = 2'd2;

endpackage

// ===== rtl/ffa_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module ffa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== rtl/first_fit_file_space_allocator.sv =====
// First-fit free extent allocator, extent list held in one RAM (start, size, version).
// Clear and append are done straight from idle. Allocate/probe read and check each extent in turn;
// when a scan closes without a fit they run a bit-serial remainder for file growth, and on an
// exact-fit allocate they remove the entry by moving each later entry up; then the item is presented.
// One item at a time. Synchronous active-low reset empties the list and loads
// register defaults; RAM contents are not cleared.
module first_fit_file_space_allocator
  import ffa_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [1:0]            in_command,
  input  logic [OFS_W-1:0]      in_request_length,
  input  logic [OFS_W-1:0]      in_current_file_size,
  input  logic [OFS_W-1:0]      in_entry_position,
  input  logic [OFS_W-1:0]      in_entry_length,
  input  logic [VER_W-1:0]      in_entry_version,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [OFS_W-1:0]      out_location,
  output logic [OFS_W-1:0]      out_new_file_size,
  output logic [1:0]            out_status,
  output logic [CNT_OUT_W-1:0]  out_extent_count,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [1:0]            cfg_index,
  input  logic [VER_W-1:0]      cfg_data
);

  localparam int AW = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CW = $clog2(MAX_EXTENTS + 1);
  localparam int DW = $clog2(OFS_W + 1);
  localparam logic [CW-1:0] TOTAL_MAX = CW'(MAX_EXTENTS);

  typedef enum logic [6:0] {
    S_IDLE    = 7'b0000001,
    S_SCAN_RD = 7'b0000010,
    S_SCAN_CK = 7'b0000100,
    S_SH_RD   = 7'b0001000,
    S_SH_WR   = 7'b0010000,
    S_DIV     = 7'b0100000,
    S_GROW    = 7'b1000000
  } state_t;

  state_t              state_r;
  logic                fin_r;
  logic                shared_r;
  logic [VER_W-1:0]    rl_r;
  logic [STEP_W-1:0]   step_r;
  logic [CW-1:0]       total_r;
  logic [CW-1:0]       k_r;
  logic [1:0]          cmd_r;
  logic [OFS_W-1:0]    len_r;
  logic [OFS_W-1:0]    old_r;
  logic [OFS_W-1:0]    q_r;
  logic [STEP_W-1:0]   rem_r;
  logic [DW-1:0]       cnt_r;
  logic [OFS_W-1:0]    res_loc_r;
  logic [OFS_W-1:0]    res_size_r;
  logic [1:0]          res_st_r;
  logic                out_valid_r;
  logic [OFS_W-1:0]    out_loc_r;
  logic [OFS_W-1:0]    out_size_r;
  logic [1:0]          out_st_r;
  logic [CNT_OUT_W-1:0] out_cnt_r;

  logic                mem_we;
  logic [AW-1:0]       mem_waddr;
  logic [ENTRY_W-1:0]  mem_wdata;
  logic [AW-1:0]       mem_raddr;
  logic [ENTRY_W-1:0]  mem_rdata;

  logic [OFS_W-1:0]    d_start, d_size;
  logic [VER_W-1:0]    d_ver;
  logic                fit, exact, in_acc, out_free, full, no_room, list_acc;
  logic [CW-1:0]       k_inc;
  logic [STEP_W-1:0]   step_eff;
  logic [STEP_W:0]     trial;
  logic [STEP_W-1:0]   pad;
  logic [OFS_W-1:0]    end_pos, slack, new_size;

  assign d_start  = mem_rdata[ENTRY_W-1 -: OFS_W];
  assign d_size   = mem_rdata[VER_W +: OFS_W];
  assign d_ver    = mem_rdata[VER_W-1:0];
  assign fit      = (len_r <= d_size) && !(shared_r && (d_ver >= rl_r));
  assign exact    = (len_r == d_size);
  assign k_inc    = k_r + CW'(1);
  assign full     = (total_r >= TOTAL_MAX);
  assign no_room  = (len_r > (OFS_MAX - old_r)) || full;
  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || fin_r || !out_free;
  assign in_acc   = in_valid && !in_stall;
  assign list_acc = in_acc && (in_command inside {CMD_CLEAR, CMD_APPEND});
  assign cfg_ready = 1'b1;

  // remainder step: shift in one bit of the request length
  assign step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
  assign trial    = {rem_r, q_r[OFS_W-1]};

  assign pad      = (rem_r != '0) ? (step_eff - rem_r) : '0;
  assign end_pos  = old_r + len_r;
  assign slack    = OFS_MAX - end_pos;
  assign new_size = (OFS_W'(pad) > slack) ? OFS_MAX : (end_pos + OFS_W'(pad));

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = k_r[AW-1:0];
    mem_wdata = mem_rdata;
    mem_raddr = k_r[AW-1:0];
    case (state_r)
      S_IDLE: begin
        mem_waddr = total_r[AW-1:0];
        mem_wdata = {in_entry_position, in_entry_length, in_entry_version};
        mem_we    = in_acc && (in_command == CMD_APPEND) && !full;
      end
      S_SCAN_CK: begin
        mem_wdata = {d_start + len_r, d_size - len_r, d_ver};
        mem_we    = fit && (cmd_r == CMD_ALLOC) && !exact;
      end
      S_SH_RD: mem_raddr = k_inc[AW-1:0];
      S_SH_WR: mem_we = 1'b1;
      S_GROW: begin
        mem_waddr = total_r[AW-1:0];
        mem_wdata = {end_pos, new_size - end_pos, {VER_W{1'b0}}};
        mem_we    = (cmd_r == CMD_ALLOC);
      end
      default: ;
    endcase
  end

  ffa_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_EXTENTS)) u_ram (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fin_r       <= 1'b0;
      shared_r    <= 1'b0;
      rl_r        <= READLOCK_RST;
      step_r      <= GROWTH_STEP_RST;
      total_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHARED:   shared_r <= cfg_data[0];
          REG_READLOCK: rl_r     <= cfg_data;
          REG_GROWTH:   step_r   <= cfg_data[STEP_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_r && !out_stall && !fin_r && !list_acc) out_valid_r <= 1'b0;

      // finished allocate/probe waits here for the output register
      if (fin_r && out_free) begin
        fin_r       <= 1'b0;
        out_valid_r <= 1'b1;
        out_loc_r   <= res_loc_r;
        out_size_r  <= res_size_r;
        out_st_r    <= res_st_r;
        out_cnt_r   <= CNT_OUT_W'(total_r);
      end

      case (state_r)
        S_IDLE: begin
          if (in_acc) begin
            cmd_r <= in_command;
            len_r <= in_request_length;
            old_r <= in_current_file_size;
            k_r   <= '0;
            case (in_command)
              CMD_CLEAR: begin
                total_r     <= '0;
                out_valid_r <= 1'b1;
                out_loc_r   <= '0;
                out_size_r  <= in_current_file_size;
                out_st_r    <= ST_LISTDONE;
                out_cnt_r   <= '0;
              end
              CMD_APPEND: begin
                out_valid_r <= 1'b1;
                out_loc_r   <= '0;
                out_size_r  <= in_current_file_size;
                out_st_r    <= full ? ST_REFUSED : ST_LISTDONE;
                out_cnt_r   <= CNT_OUT_W'(full ? total_r : total_r + CW'(1));
                if (!full) total_r <= total_r + CW'(1);
              end
              default: state_r <= S_SCAN_RD;
            endcase
          end
        end
        S_SCAN_RD: begin
          if (k_r < total_r) begin
            state_r <= S_SCAN_CK;
          end else if (no_room) begin
            res_loc_r  <= '0;
            res_size_r <= old_r;
            res_st_r   <= ST_REFUSED;
            fin_r      <= 1'b1;
            state_r    <= S_IDLE;
          end else begin
            q_r     <= len_r;
            rem_r   <= '0;
            cnt_r   <= DW'(OFS_W);
            state_r <= S_DIV;
          end
        end
        S_SCAN_CK: begin
          if (fit) begin
            res_loc_r  <= d_start;
            res_size_r <= old_r;
            res_st_r   <= ST_REUSED;
            if ((cmd_r == CMD_ALLOC) && exact) begin
              state_r <= S_SH_RD;
            end else begin
              fin_r   <= 1'b1;
              state_r <= S_IDLE;
            end
          end else begin
            k_r     <= k_inc;
            state_r <= S_SCAN_RD;
          end
        end
        S_SH_RD: begin
          if (k_inc < total_r) begin
            state_r <= S_SH_WR;
          end else begin
            total_r <= total_r - CW'(1);
            fin_r   <= 1'b1;
            state_r <= S_IDLE;
          end
        end
        S_SH_WR: begin
          k_r     <= k_inc;
          state_r <= S_SH_RD;
        end
        S_DIV: begin
          q_r   <= q_r << 1;
          rem_r <= (trial >= {1'b0, step_eff}) ? STEP_W'(trial - {1'b0, step_eff})
                                                : trial[STEP_W-1:0];
          cnt_r <= cnt_r - DW'(1);
          if (cnt_r == DW'(1)) state_r <= S_GROW;
        end
        S_GROW: begin
          res_loc_r  <= old_r;
          res_size_r <= new_size;
          res_st_r   <= ST_EXPANDED;
          if (cmd_r == CMD_ALLOC) total_r <= total_r + CW'(1);
          fin_r   <= 1'b1;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid         = out_valid_r;
  assign out_location      = out_loc_r;
  assign out_new_file_size = out_size_r;
  assign out_status        = out_st_r;
  assign out_extent_count  = out_cnt_r;

endmodule

// ===== rtl/ffa_chk.sv =====
// Port-level checks for the first-fit file space allocator, bound to the top level.
// Depends on ffa_pkg for widths and status codes.
module ffa_chk
  import ffa_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input logic                  out_valid,
  input logic                  out_stall,
  input logic [OFS_W-1:0]      out_location,
  input logic [OFS_W-1:0]      out_new_file_size,
  input logic [1:0]            out_status,
  input logic [CNT_OUT_W-1:0]  out_extent_count
);

  // a result still waiting blocks the next item
  a_wait_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall) else $error("item taken while result stalled");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid) else $error("stalled item withdrawn");

  a_list_loc: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ST_LISTDONE || out_status == ST_REFUSED)
    |-> out_location == '0) else $error("non-zero location on list command or refusal");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_file_size)
    && $stable(out_extent_count)) else $error("stalled result changed");

  a_rst: assert property (@(posedge clk)
    !rst_n |=> !out_valid) else $error("result valid after reset");

endmodule

bind first_fit_file_space_allocator ffa_chk u_ffa_chk (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_valid),
  .in_stall          (in_stall),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_location      (out_location),
  .out_new_file_size (out_new_file_size),
  .out_status        (out_status),
  .out_extent_count  (out_extent_count)
);
